/* hdl/vssc_pkg.sv */
// ----------------------------------------------------------------------------
// vssc_pkg
// Shared codes and types of the voice stream session controller: event
// opcodes, control commands, stream modes, register map and bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package vssc_pkg;

   // field widths of one item
   localparam int unsigned OPCODE_W  = 4;
   localparam int unsigned COMMAND_W = 8;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned TICKS_W   = 16;

   // event opcodes
   localparam logic [OPCODE_W-1:0] OP_CONTROL    = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_LINK_UP    = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_LINK_DOWN  = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_SUBSCRIBE  = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_TICK       = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_BEGIN      = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_END        = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_CLEAR      = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_CONSUME    = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_AUDIO_FAIL = 4'd9;

   // host control commands
   localparam logic [COMMAND_W-1:0] CMD_DISABLE     = 8'd0;
   localparam logic [COMMAND_W-1:0] CMD_CONTINUOUS  = 8'd1;
   localparam logic [COMMAND_W-1:0] CMD_ARMED       = 8'd2;
   localparam logic [COMMAND_W-1:0] CMD_VOICE_START = 8'd3;
   localparam logic [COMMAND_W-1:0] CMD_VOICE_STOP  = 8'd4;

   // stream modes
   localparam logic [MODE_W-1:0] MODE_DISABLED   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ARMED      = 2'd2;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_STOP_TAIL     = 1'b0;
   localparam logic REG_START_TIMEOUT = 1'b1;

   localparam logic [TICKS_W-1:0] STOP_TAIL_RESET     = 16'd400;
   localparam logic [TICKS_W-1:0] START_TIMEOUT_RESET = 16'd6000;
   localparam logic [TICKS_W-1:0] AGE_MAX             = 16'hFFFF;

   // register values seen by the session logic
   typedef struct packed {
      logic [TICKS_W-1:0] stop_tail_ticks;
      logic [TICKS_W-1:0] start_timeout_ticks;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic              streaming;
      logic              transport_ready;
      logic [MODE_W-1:0] stream_mode;
      logic              session_interrupted;
      logic              timeout_taken;
      logic              new_session;
      logic              bad_command;
   } result_type;

endpackage

`default_nettype wire

/* hdl/vssc_req_if.sv */
// ----------------------------------------------------------------------------
// vssc_req_if
// Event channel: valid/ready handshake with opcode, command and subscription.
// ----------------------------------------------------------------------------
`default_nettype none

interface vssc_req_if;
   logic                               valid;
   logic                               ready;
   logic [vssc_pkg::OPCODE_W-1:0]      opcode;
   logic [vssc_pkg::COMMAND_W-1:0]     command;
   logic                               subscribe_on;

   modport source (output valid, output opcode, output command, output subscribe_on,
                   input ready);
   modport sink   (input valid, input opcode, input command, input subscribe_on,
                   output ready);
endinterface

`default_nettype wire

/* hdl/vssc_rsp_if.sv */
// ----------------------------------------------------------------------------
// vssc_rsp_if
// Result channel: valid/ready handshake with the session status of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface vssc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           streaming;
   logic                           transport_ready;
   logic [vssc_pkg::MODE_W-1:0]    stream_mode;
   logic                           session_interrupted;
   logic                           timeout_taken;
   logic                           new_session;
   logic                           bad_command;

   modport source (output valid, output streaming, output transport_ready,
                   output stream_mode, output session_interrupted, output timeout_taken,
                   output new_session, output bad_command, input ready);
   modport sink   (input valid, input streaming, input transport_ready,
                   input stream_mode, input session_interrupted, input timeout_taken,
                   input new_session, input bad_command, output ready);
endinterface

`default_nettype wire

/* hdl/vssc_csr.sv */
// ----------------------------------------------------------------------------
// vssc_csr
// APB-style register file holding the stop tail and start timeout limits.
// ----------------------------------------------------------------------------
`default_nettype none

module vssc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [vssc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [vssc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [vssc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready,
   output vssc_pkg::cfg_type                        cfg
);

   logic [vssc_pkg::TICKS_W-1:0] stop_tail_ff;
   logic [vssc_pkg::TICKS_W-1:0] start_timeout_ff;
   logic                         wr_en;
   logic                         reg_sel;

   // word-aligned decode, one bit picks the register
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_tail_ff     <= vssc_pkg::STOP_TAIL_RESET;
         start_timeout_ff <= vssc_pkg::START_TIMEOUT_RESET;
      end else if (wr_en) begin
         if (reg_sel == vssc_pkg::REG_STOP_TAIL) begin
            stop_tail_ff <= pwdata[vssc_pkg::TICKS_W-1:0];
         end else begin
            start_timeout_ff <= pwdata[vssc_pkg::TICKS_W-1:0];
         end
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (reg_sel == vssc_pkg::REG_STOP_TAIL) begin
         prdata[vssc_pkg::TICKS_W-1:0] = stop_tail_ff;
      end else begin
         prdata[vssc_pkg::TICKS_W-1:0] = start_timeout_ff;
      end
   end

   assign cfg.stop_tail_ticks     = stop_tail_ff;
   assign cfg.start_timeout_ticks = start_timeout_ff;

endmodule

`default_nettype wire

/* hdl/vssc_core.sv */
// ----------------------------------------------------------------------------
// vssc_core
// Session state and its single-pass update: one event in, next state and one
// result out. State commits only when the item is handed on.
// ----------------------------------------------------------------------------
`default_nettype none

module vssc_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire vssc_pkg::cfg_type                  cfg,
   input  wire logic                               enable,
   input  wire logic [vssc_pkg::OPCODE_W-1:0]      opcode,
   input  wire logic [vssc_pkg::COMMAND_W-1:0]     command,
   input  wire logic                               subscribe_on,
   output vssc_pkg::result_type                    result
);

   typedef struct packed {
      logic [vssc_pkg::MODE_W-1:0]  mode;
      logic                         link_up;
      logic                         audio_subscribed;
      logic                         voice_intent;
      logic                         voice_requested;
      logic                         interrupted;
      logic                         timeout;
      logic                         intent_waiting;
      logic [vssc_pkg::TICKS_W-1:0] intent_age;
      logic                         stop_pending;
      logic [vssc_pkg::TICKS_W-1:0] stop_age;
   } state_type;

   typedef struct packed {
      state_type s;
      logic      pulse;
   } work_type;

   state_type state_ff;
   work_type  work_in;
   logic      taken_in;
   logic      bad_in;

   function automatic logic stream_live(state_type s);
      return s.link_up && s.audio_subscribed &&
             ((s.mode == vssc_pkg::MODE_CONTINUOUS) ||
              ((s.mode == vssc_pkg::MODE_ARMED) && s.voice_requested));
   endfunction

   // start a latched voice intent once the path is up and armed
   function automatic work_type try_start(work_type w);
      work_type r;
      r = w;
      if (r.s.voice_intent && (r.s.mode == vssc_pkg::MODE_ARMED) &&
          r.s.link_up && r.s.audio_subscribed) begin
         r.s.stop_pending   = 1'b0;
         r.s.stop_age       = '0;
         r.s.intent_waiting = 1'b0;
         r.s.intent_age     = '0;
         r.s.interrupted    = 1'b0;
         if (!r.s.voice_requested) begin
            r.s.voice_requested = 1'b1;
            r.pulse             = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic work_type voice_start(work_type w);
      work_type r;
      r = w;
      if (!r.s.voice_intent) begin
         r.s.voice_intent   = 1'b1;
         r.s.intent_waiting = 1'b1;
         r.s.intent_age     = '0;
         r.s.timeout        = 1'b0;
      end
      return try_start(r);
   endfunction

   function automatic work_type end_stream(work_type w, logic now);
      work_type r;
      r = w;
      if (!r.s.voice_requested || now) begin
         r.s.stop_pending = 1'b0;
         r.s.stop_age     = '0;
         r.s.voice_requested = 1'b0;
      end else begin
         r.s.stop_pending = 1'b1;
         r.s.stop_age     = '0;
      end
      return r;
   endfunction

   function automatic work_type voice_stop(work_type w, logic now);
      work_type r;
      r = w;
      r.s.voice_intent   = 1'b0;
      r.s.intent_waiting = 1'b0;
      r.s.intent_age     = '0;
      return end_stream(r, now);
   endfunction

   // age both timers, then check the start timeout and the stop deadline
   function automatic work_type do_tick(work_type w, vssc_pkg::cfg_type c);
      work_type r;
      r = w;
      if (r.s.intent_waiting && (r.s.intent_age != vssc_pkg::AGE_MAX)) begin
         r.s.intent_age = r.s.intent_age + 16'd1;
      end
      if (r.s.stop_pending && (r.s.stop_age != vssc_pkg::AGE_MAX)) begin
         r.s.stop_age = r.s.stop_age + 16'd1;
      end
      if (r.s.voice_intent && !r.s.voice_requested && r.s.intent_waiting &&
          (r.s.intent_age >= c.start_timeout_ticks)) begin
         r.s.voice_intent   = 1'b0;
         r.s.intent_waiting = 1'b0;
         r.s.intent_age     = '0;
         r.s.timeout        = 1'b1;
         r.s.interrupted    = 1'b1;
      end
      if (r.s.stop_pending && (r.s.stop_age >= c.stop_tail_ticks)) begin
         r.s.stop_pending    = 1'b0;
         r.s.stop_age        = '0;
         r.s.voice_requested = 1'b0;
      end
      return r;
   endfunction

   function automatic work_type link_down(work_type w);
      work_type r;
      r = w;
      if ((r.s.voice_intent || r.s.voice_requested) && !r.s.stop_pending) begin
         r.s.interrupted = 1'b1;
      end
      r.s.link_up          = 1'b0;
      r.s.audio_subscribed = 1'b0;
      r.s.mode             = vssc_pkg::MODE_DISABLED;
      r.s.voice_intent     = 1'b0;
      r.s.voice_requested  = 1'b0;
      r.s.intent_waiting   = 1'b0;
      r.s.intent_age       = '0;
      r.s.timeout          = 1'b0;
      r.s.stop_pending     = 1'b0;
      r.s.stop_age         = '0;
      return r;
   endfunction

   // event decode and next state
   always_comb begin
      work_in.s     = state_ff;
      work_in.pulse = 1'b0;
      taken_in      = 1'b0;
      bad_in        = 1'b0;
      unique case (opcode)
         vssc_pkg::OP_CONTROL: begin
            unique case (command)
               vssc_pkg::CMD_DISABLE: begin
                  work_in.s.mode = vssc_pkg::MODE_DISABLED;
                  work_in = voice_stop(work_in, 1'b1);
               end
               vssc_pkg::CMD_CONTINUOUS: begin
                  work_in.s.mode            = vssc_pkg::MODE_CONTINUOUS;
                  work_in.s.voice_intent    = 1'b0;
                  work_in.s.intent_waiting  = 1'b0;
                  work_in.s.intent_age      = '0;
                  work_in.s.stop_pending    = 1'b0;
                  work_in.s.stop_age        = '0;
                  work_in.s.voice_requested = 1'b0;
                  work_in.pulse             = 1'b1;
               end
               vssc_pkg::CMD_ARMED: begin
                  work_in.s.mode = vssc_pkg::MODE_ARMED;
                  work_in = try_start(end_stream(work_in, 1'b1));
               end
               vssc_pkg::CMD_VOICE_START: work_in = voice_start(work_in);
               vssc_pkg::CMD_VOICE_STOP:  work_in = voice_stop(work_in, 1'b0);
               default:                   bad_in  = 1'b1;
            endcase
         end
         vssc_pkg::OP_LINK_UP:   work_in.s.link_up = 1'b1;
         vssc_pkg::OP_LINK_DOWN: work_in = link_down(work_in);
         vssc_pkg::OP_SUBSCRIBE: begin
            work_in.s.audio_subscribed = subscribe_on;
            if (subscribe_on) begin
               work_in = try_start(work_in);
            end
         end
         vssc_pkg::OP_TICK:  work_in = do_tick(work_in, cfg);
         vssc_pkg::OP_BEGIN: work_in = voice_start(work_in);
         vssc_pkg::OP_END:   work_in = voice_stop(work_in, 1'b0);
         vssc_pkg::OP_CLEAR: work_in.s.interrupted = 1'b0;
         vssc_pkg::OP_CONSUME: begin
            taken_in          = state_ff.timeout;
            work_in.s.timeout = 1'b0;
         end
         vssc_pkg::OP_AUDIO_FAIL: begin
            // a failure is only visible while the stream runs
            if (stream_live(state_ff)) begin
               work_in.s.interrupted     = 1'b1;
               work_in.s.voice_requested = 1'b0;
               if (state_ff.mode == vssc_pkg::MODE_CONTINUOUS) begin
                  work_in.s.mode = vssc_pkg::MODE_DISABLED;
               end
            end
         end
         default: ;
      endcase
   end

   // result from the state after the event
   always_comb begin
      result.streaming           = stream_live(work_in.s);
      result.transport_ready     = work_in.s.link_up && work_in.s.audio_subscribed &&
                                   (work_in.s.mode == vssc_pkg::MODE_ARMED);
      result.stream_mode         = work_in.s.mode;
      result.session_interrupted = work_in.s.interrupted;
      result.timeout_taken       = taken_in;
      result.new_session         = work_in.pulse;
      result.bad_command         = bad_in;
   end

   // state commit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (enable) begin
         state_ff <= work_in.s;
      end
   end

endmodule

`default_nettype wire

/* hdl/voice_stream_session_controller.sv */
// ----------------------------------------------------------------------------
// voice_stream_session_controller
// Pipeline: two register stages (input register, then result register); an
// item waits in the input register until the result register is free or taken.
// Throughput: 1 item per cycle while the result side takes items.
// Reset: synchronous, clears both stages and all session state; the limits
// return to 400 and 6000 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_stream_session_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   vssc_req_if.sink                                 req_if,
   vssc_rsp_if.source                               rsp_if,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [vssc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [vssc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [vssc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready
);

   vssc_pkg::cfg_type              cfg;
   vssc_pkg::result_type           result;
   vssc_pkg::result_type           rsp_data_ff;
   logic                           rsp_valid_ff;
   logic                           in_valid_ff;
   logic [vssc_pkg::OPCODE_W-1:0]  in_opcode_ff;
   logic [vssc_pkg::COMMAND_W-1:0] in_command_ff;
   logic                           in_subscribe_ff;
   logic                           advance;
   logic                           take;

   vssc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // stage handshake
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign take         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_opcode_ff    <= req_if.opcode;
         in_command_ff   <= req_if.command;
         in_subscribe_ff <= req_if.subscribe_on;
      end
   end

   vssc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .enable       (take),
      .opcode       (in_opcode_ff),
      .command      (in_command_ff),
      .subscribe_on (in_subscribe_ff),
      .result       (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.streaming           = rsp_data_ff.streaming;
   assign rsp_if.transport_ready     = rsp_data_ff.transport_ready;
   assign rsp_if.stream_mode         = rsp_data_ff.stream_mode;
   assign rsp_if.session_interrupted = rsp_data_ff.session_interrupted;
   assign rsp_if.timeout_taken       = rsp_data_ff.timeout_taken;
   assign rsp_if.new_session         = rsp_data_ff.new_session;
   assign rsp_if.bad_command         = rsp_data_ff.bad_command;

   // a pending item moves into a free result register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending item did not reach the result register");

   // a blocked input item is kept unchanged
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_opcode_ff)))
      else $error("blocked input item was lost or overwritten");

   // a streaming result never reports the disabled mode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.streaming) |->
      (rsp_data_ff.stream_mode != vssc_pkg::MODE_DISABLED))
      else $error("streaming reported in disabled mode");

   // a rejected command never starts a session
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.bad_command && rsp_data_ff.new_session))
      else $error("rejected command started a session");

endmodule

`default_nettype wire
